[design/hkt_pkg.sv]
// Package for the HID keystroke typer: request and result types,
// controller/datapath link types, constants and the ASCII-to-usage map.
// Depends on nothing.
package hkt_pkg;

    localparam int          DEFAULT_BUFFER_DEPTH = 64;
    localparam logic [15:0] PRESS_TICKS_RESET    = 16'd50;
    localparam logic [15:0] GAP_TICKS_RESET      = 16'd200;

    localparam logic [7:0] MOD_NONE  = 8'h00;
    localparam logic [7:0] MOD_SHIFT = 8'h02;
    localparam logic [7:0] MOD_GUI   = 8'h08;
    localparam logic [7:0] KEY_SPACE = 8'h2C;
    localparam logic [7:0] KEY_NONE  = 8'h00;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam int          CFG_ADDR_W    = 3;
    localparam logic        REG_PRESS     = 1'b0;
    localparam logic        REG_GAP       = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_code;
        logic       is_release;
        logic       string_done;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic do_read;
        logic do_press;
    } t_ctrl_cmd;

    typedef struct packed {
        logic press_req;
    } t_dp_status;

    function automatic t_out_item map_char(input logic [7:0] c);
        t_out_item r;
        r.modifier_bits = MOD_NONE;
        r.key_code      = KEY_SPACE;
        r.is_release    = 1'b0;
        r.string_done   = 1'b0;
        case (c) inside
            [8'h61:8'h7A]: r.key_code = c - 8'h5D;
            [8'h41:8'h5A]: begin
                r.key_code      = c - 8'h3D;
                r.modifier_bits = MOD_SHIFT;
            end
            [8'h31:8'h39]: r.key_code = c - 8'h13;
            8'h30: r.key_code = 8'h27;
            8'h2D: r.key_code = 8'h2D;
            8'h2F: r.key_code = 8'h38;
            8'h2E: r.key_code = 8'h37;
            8'h0D: r.key_code = 8'h28;
            8'h01: begin
                r.key_code      = 8'h15;
                r.modifier_bits = MOD_GUI;
            end
            8'h7E: begin r.key_code = 8'h32; r.modifier_bits = MOD_SHIFT; end
            8'h21: begin r.key_code = 8'h1E; r.modifier_bits = MOD_SHIFT; end
            8'h40: begin r.key_code = 8'h1F; r.modifier_bits = MOD_SHIFT; end
            8'h23: begin r.key_code = 8'h20; r.modifier_bits = MOD_SHIFT; end
            8'h24: begin r.key_code = 8'h21; r.modifier_bits = MOD_SHIFT; end
            8'h25: begin r.key_code = 8'h22; r.modifier_bits = MOD_SHIFT; end
            8'h5E: begin r.key_code = 8'h23; r.modifier_bits = MOD_SHIFT; end
            8'h26: begin r.key_code = 8'h24; r.modifier_bits = MOD_SHIFT; end
            8'h2A: begin r.key_code = 8'h25; r.modifier_bits = MOD_SHIFT; end
            8'h28: begin r.key_code = 8'h26; r.modifier_bits = MOD_SHIFT; end
            8'h29: begin r.key_code = 8'h27; r.modifier_bits = MOD_SHIFT; end
            8'h2B: begin r.key_code = 8'h2E; r.modifier_bits = MOD_SHIFT; end
            8'h3A: begin r.key_code = 8'h33; r.modifier_bits = MOD_SHIFT; end
            default: r.key_code = KEY_SPACE;
        endcase
        return r;
    endfunction

endpackage

[design/hkt_ctrl.sv]
// Controller state machine of the HID keystroke typer.
// Sequences request acceptance, the text store read and the press report.
// Depends on hkt_pkg.
module hkt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  hkt_pkg::t_dp_status i_status,
    output hkt_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_busy
);
    import hkt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_PRESS = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_status.press_req) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_PRESS;
            end
            S_PRESS: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept   = accept;
    assign o_cmd.do_read  = (r_state == S_READ);
    assign o_cmd.do_press = (r_state == S_PRESS);
    assign o_busy         = (r_state != S_IDLE);

    a_read_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.press_req) |=> (r_state == S_READ))
        else $error("press request did not enter the read state");
    a_press_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_PRESS))
        else $error("read state not followed by press state");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_cmd.accept)
        else $error("request accepted while busy");

endmodule

[design/hkt_datapath.sv]
// Datapath of the HID keystroke typer: text store, string counters,
// tick countdown, key mapping and the result register.
// Depends on hkt_pkg.
module hkt_datapath #(
    parameter int BUFFER_DEPTH = hkt_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hkt_pkg::t_ctrl_cmd  i_cmd,
    input  hkt_pkg::t_in_item   i_item,
    input  logic [15:0]         i_press_ticks,
    input  logic [15:0]         i_gap_ticks,
    output hkt_pkg::t_dp_status o_status,
    output logic                o_valid,
    output hkt_pkg::t_out_item  o_result
);
    import hkt_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUFFER_DEPTH - 1);

    logic [7:0]       r_mem [BUFFER_DEPTH];
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_load_count, n_load_count;
    logic [IDX_W-1:0] r_read_index, n_read_index;
    logic [CNT_W-1:0] r_chars_left, n_chars_left;
    logic             r_release_next, n_release_next;
    logic             r_typing, n_typing;
    logic [15:0]      r_countdown, n_countdown;
    logic             r_valid, n_valid;
    t_out_item        r_result, n_result;

    logic             mem_we;
    logic [CNT_W-1:0] cnt_after;
    logic             press_req;

    always_comb begin
        n_load_count   = r_load_count;
        n_read_index   = r_read_index;
        n_chars_left   = r_chars_left;
        n_release_next = r_release_next;
        n_typing       = r_typing;
        n_countdown    = r_countdown;
        n_valid        = 1'b0;
        n_result       = r_result;
        mem_we         = 1'b0;
        press_req      = 1'b0;
        cnt_after      = r_load_count;
        if (i_cmd.accept) begin
            if (i_item.cmd == CMD_LOAD) begin
                if (!r_typing) begin
                    if (r_load_count < DEPTH_CNT) begin
                        mem_we    = 1'b1;
                        cnt_after = r_load_count + CNT_W'(1);
                    end
                    if (i_item.last_char) begin
                        n_typing     = 1'b1;
                        n_read_index = '0;
                        n_chars_left = cnt_after - CNT_W'(1);
                        n_load_count = '0;
                        press_req    = 1'b1;
                    end else begin
                        n_load_count = cnt_after;
                    end
                end
            end else if (r_typing) begin
                if (r_countdown > 16'd1) begin
                    n_countdown = r_countdown - 16'd1;
                end else if (r_release_next) begin
                    n_valid                = 1'b1;
                    n_result.modifier_bits = MOD_NONE;
                    n_result.key_code      = KEY_NONE;
                    n_result.is_release    = 1'b1;
                    n_release_next         = 1'b0;
                    if (r_chars_left == '0) begin
                        n_result.string_done = 1'b1;
                        n_typing             = 1'b0;
                        n_countdown          = '0;
                        n_read_index         = '0;
                    end else begin
                        n_result.string_done = 1'b0;
                        n_countdown          = i_gap_ticks;
                    end
                end else begin
                    n_chars_left = r_chars_left - CNT_W'(1);
                    press_req    = 1'b1;
                end
            end
        end
        if (i_cmd.do_press) begin
            n_valid        = 1'b1;
            n_result       = map_char(r_rd_data);
            n_read_index   = (r_read_index == LAST_IDX) ? '0 : r_read_index + IDX_W'(1);
            n_release_next = 1'b1;
            n_countdown    = i_press_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_load_count[IDX_W-1:0]] <= i_item.char_code;
        end
        if (i_cmd.do_read) begin
            r_rd_data <= r_mem[r_read_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count   <= '0;
            r_read_index   <= '0;
            r_chars_left   <= '0;
            r_release_next <= 1'b0;
            r_typing       <= 1'b0;
            r_countdown    <= '0;
            r_valid        <= 1'b0;
        end else begin
            r_load_count   <= n_load_count;
            r_read_index   <= n_read_index;
            r_chars_left   <= n_chars_left;
            r_release_next <= n_release_next;
            r_typing       <= n_typing;
            r_countdown    <= n_countdown;
            r_valid        <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_status.press_req = press_req;
    assign o_valid            = r_valid;
    assign o_result           = r_result;

    a_release_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.is_release) |->
        (r_result.key_code == KEY_NONE && r_result.modifier_bits == MOD_NONE))
        else $error("release report carries a key");
    a_done_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.string_done) |-> (r_result.is_release && !r_typing))
        else $error("string end flagged on a non-final report");
    a_typing_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_typing |-> (r_load_count == '0))
        else $error("load count nonzero while typing");
    a_press_while_typing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_press |-> (r_typing && !r_release_next))
        else $error("press issued outside a typing pass");

endmodule

[design/hid_keystroke_typer_top.sv]
// Top level of the HID keystroke typer: APB timing registers and the
// controller and datapath instances.
// Depends on hkt_pkg, hkt_ctrl and hkt_datapath.
// A release report is registered and appears in the cycle after its
// request; a press report passes the read and press states and then the
// result register, with busy high in both states. A request that gives
// no press leaves the controller ready for the next one. Reset is
// synchronous and clears control state and the timing registers;
// the text store is not cleared. The receiver cannot stall results.
module hid_keystroke_typer_top #(
    parameter int BUFFER_DEPTH = hkt_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  hkt_pkg::t_in_item             i_item,
    output logic                          o_valid,
    output hkt_pkg::t_out_item            o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hkt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import hkt_pkg::*;

    logic [15:0] r_press_ticks;
    logic [15:0] r_gap_ticks;
    logic        cfg_we;
    t_ctrl_cmd   cmd;
    t_dp_status  status;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks <= PRESS_TICKS_RESET;
            r_gap_ticks   <= GAP_TICKS_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == REG_PRESS) begin
                r_press_ticks <= pwdata[15:0];
            end else begin
                r_gap_ticks <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GAP) ? {16'd0, r_gap_ticks} : {16'd0, r_press_ticks};

    hkt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    hkt_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_item        (i_item),
        .i_press_ticks (r_press_ticks),
        .i_gap_ticks   (r_gap_ticks),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

endmodule
